@@ rtl/xcr_pkg.sv @@
// Shared types, protocol byte codes and the CRC step for the XMODEM-CRC receiver.
// Used by every module of the block; depends on nothing else.

package xcr_pkg;

   // Protocol bytes
   localparam logic [7:0] BYTE_SOH = 8'h01;
   localparam logic [7:0] BYTE_EOT = 8'h04;
   localparam logic [7:0] BYTE_ACK = 8'h06;
   localparam logic [7:0] BYTE_NAK = 8'h15;
   localparam logic [7:0] BYTE_CAN = 8'h18;
   localparam logic [7:0] BYTE_C   = 8'h43;

   // CRC-16/XMODEM polynomial
   localparam logic [15:0] CRC_POLY = 16'h1021;

   // Retry count left behind when a retry runs out
   localparam logic [7:0] RETRY_AFTER_ABORT = 8'd4;

   // Width of the packet byte counter
   localparam int INDEX_W = 11;

   // Input action codes
   localparam logic [1:0] ACT_TICK   = 2'd0;
   localparam logic [1:0] ACT_BYTE   = 2'd1;
   localparam logic [1:0] ACT_CANCEL = 2'd2;
   localparam logic [1:0] ACT_START  = 2'd3;

   // Verdict codes
   localparam logic [1:0] VERDICT_NONE    = 2'd0;
   localparam logic [1:0] VERDICT_NEW     = 2'd1;
   localparam logic [1:0] VERDICT_DUP     = 2'd2;
   localparam logic [1:0] VERDICT_CORRUPT = 2'd3;

   // Session end codes
   localparam logic [1:0] END_RUNNING = 2'd0;
   localparam logic [1:0] END_EOT     = 2'd1;
   localparam logic [1:0] END_SENDER  = 2'd2;
   localparam logic [1:0] END_ABORT   = 2'd3;

   // Configuration register indexes
   localparam logic [1:0] REG_RETRY_LIMIT   = 2'd0;
   localparam logic [1:0] REG_FIRST_TIMEOUT = 2'd1;
   localparam logic [1:0] REG_BYTE_TIMEOUT  = 2'd2;

   // Queue between the front and back parts
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_WAIT = 2'd1,
      PH_PART = 2'd2,
      PH_CAN1 = 2'd3
   } phase_type;

   // How one queued entry expands into result items
   typedef enum logic [1:0] {
      KIND_ONE   = 2'd0,
      KIND_CAN2  = 2'd1,
      KIND_ABORT = 2'd2
   } kind_type;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       data_valid;
      logic [7:0] data_byte;
      logic [1:0] verdict;
      logic [1:0] session_end;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  retry_limit;
      logic [15:0] first_timeout_ticks;
      logic [15:0] byte_timeout_ticks;
   } cfg_type;

   typedef struct packed {
      kind_type   kind;
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       data_valid;
      logic [7:0] data_byte;
      logic [1:0] verdict;
      logic [1:0] session_end;
   } desc_type;

   // One byte through the CRC-16/XMODEM register, MSB first
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

@@ rtl/xcr_queue.sv @@
// Short descriptor queue between the front and back parts of the receiver.
// Depends on xcr_pkg for the descriptor type and depth.

module xcr_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  xcr_pkg::desc_type push_desc,
   output logic              full,
   input  logic              pop,
   output xcr_pkg::desc_type head,
   output logic              empty
);

   xcr_pkg::desc_type            entries_ff [xcr_pkg::QUEUE_DEPTH];
   logic [xcr_pkg::QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [xcr_pkg::QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [xcr_pkg::QPTR_W:0]     count_ff, count_in;
   logic                         do_push, do_pop;

   assign full    = (count_ff == (xcr_pkg::QPTR_W+1)'(xcr_pkg::QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = entries_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

@@ rtl/xcr_front.sv @@
// Front part of the receiver: accepts items, runs the session state machine and
// queues one descriptor per item that produces results. Depends on xcr_pkg.

module xcr_front #(
   parameter int PACKET_BYTES = 128
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_stall,
   input  xcr_pkg::req_type  in_item,
   input  xcr_pkg::cfg_type  cfg,
   output logic              push,
   output xcr_pkg::desc_type push_desc,
   input  logic              q_full
);

   localparam logic [xcr_pkg::INDEX_W-1:0] DATA_END =
      xcr_pkg::INDEX_W'(PACKET_BYTES + 3);

   xcr_pkg::phase_type            phase_ff, phase_in;
   logic [7:0]                    reply_ff, reply_in;
   logic [7:0]                    exp_seq_ff, exp_seq_in;
   logic [7:0]                    retries_ff, retries_in;
   logic                          flushing_ff, flushing_in;
   logic [15:0]                   timeout_ff, timeout_in;
   logic [xcr_pkg::INDEX_W-1:0]   index_ff, index_in;
   logic [15:0]                   crc_ff, crc_in;
   logic [7:0]                    hseq_ff, hseq_in;
   logic [7:0]                    hinv_ff, hinv_in;
   logic [15:0]                   rcrc_ff, rcrc_in;

   logic        accept;
   logic [7:0]  b;
   logic [15:0] crc_next;
   logic [15:0] rcrc_full;
   logic        retry_hit;
   logic [7:0]  retries_used;
   logic        pkt_good;

   assign in_stall  = q_full;
   assign accept    = in_valid && !q_full;
   assign b         = in_item.rx_byte;
   assign crc_next  = xcr_pkg::crc_byte(crc_ff, b);
   assign rcrc_full = {rcrc_ff[15:8], b};
   assign pkt_good  = (hseq_ff == ~hinv_ff) && (crc_ff == rcrc_full);

   // Retries run out at a count of one; the count then becomes RETRY_AFTER_ABORT
   assign retry_hit    = (retries_ff == 8'd1);
   assign retries_used = (retries_ff == 8'd0) ? retries_ff :
                         (retry_hit ? xcr_pkg::RETRY_AFTER_ABORT : retries_ff - 8'd1);

   // Session state machine: next state and the descriptor to queue
   always_comb begin
      phase_in    = phase_ff;
      reply_in    = reply_ff;
      exp_seq_in  = exp_seq_ff;
      retries_in  = retries_ff;
      flushing_in = flushing_ff;
      timeout_in  = timeout_ff;
      index_in    = index_ff;
      crc_in      = crc_ff;
      hseq_in     = hseq_ff;
      hinv_in     = hinv_ff;
      rcrc_in     = rcrc_ff;
      push        = 1'b0;
      push_desc   = '0;
      push_desc.kind = xcr_pkg::KIND_ONE;

      if (accept) begin
         priority if (in_item.action == xcr_pkg::ACT_START) begin
            // Restart the session and solicit with 'C'
            phase_in    = xcr_pkg::PH_WAIT;
            reply_in    = xcr_pkg::BYTE_C;
            exp_seq_in  = 8'd1;
            retries_in  = cfg.retry_limit;
            flushing_in = 1'b0;
            timeout_in  = cfg.first_timeout_ticks;
            index_in    = '0;
            crc_in      = '0;
            hseq_in     = '0;
            hinv_in     = '0;
            rcrc_in     = '0;
            push        = 1'b1;
            push_desc.tx_valid = 1'b1;
            push_desc.tx_byte  = xcr_pkg::BYTE_C;
         end else if (phase_ff == xcr_pkg::PH_IDLE) begin
            // Nothing happens while no session runs
         end else if (in_item.action == xcr_pkg::ACT_CANCEL) begin
            phase_in       = xcr_pkg::PH_IDLE;
            push           = 1'b1;
            push_desc.kind = xcr_pkg::KIND_CAN2;
         end else if (in_item.action == xcr_pkg::ACT_TICK) begin
            if (timeout_ff <= 16'd1) begin
               // Timeout
               timeout_in  = cfg.byte_timeout_ticks;
               flushing_in = 1'b0;
               retries_in  = retries_used;
               if (retry_hit) begin
                  phase_in       = xcr_pkg::PH_IDLE;
                  flushing_in    = 1'b1;
                  push           = 1'b1;
                  push_desc.kind = xcr_pkg::KIND_ABORT;
               end else if (phase_ff == xcr_pkg::PH_WAIT) begin
                  push               = 1'b1;
                  push_desc.tx_valid = 1'b1;
                  push_desc.tx_byte  = reply_ff;
               end else if (phase_ff == xcr_pkg::PH_PART) begin
                  reply_in           = xcr_pkg::BYTE_NAK;
                  phase_in           = xcr_pkg::PH_WAIT;
                  push               = 1'b1;
                  push_desc.tx_valid = 1'b1;
                  push_desc.tx_byte  = xcr_pkg::BYTE_NAK;
               end
            end else begin
               timeout_in = timeout_ff - 16'd1;
            end
         end else if (!flushing_ff) begin
            // Received byte
            timeout_in = cfg.byte_timeout_ticks;
            unique case (phase_ff)
               xcr_pkg::PH_WAIT: begin
                  if (b == xcr_pkg::BYTE_SOH) begin
                     index_in = xcr_pkg::INDEX_W'(1);
                     crc_in   = '0;
                     phase_in = xcr_pkg::PH_PART;
                  end else if (b == xcr_pkg::BYTE_EOT) begin
                     flushing_in           = 1'b1;
                     reply_in              = xcr_pkg::BYTE_ACK;
                     phase_in              = xcr_pkg::PH_IDLE;
                     push                  = 1'b1;
                     push_desc.tx_valid    = 1'b1;
                     push_desc.tx_byte     = xcr_pkg::BYTE_ACK;
                     push_desc.session_end = xcr_pkg::END_EOT;
                  end else if (b == xcr_pkg::BYTE_CAN) begin
                     phase_in = xcr_pkg::PH_CAN1;
                  end
               end
               xcr_pkg::PH_CAN1: begin
                  flushing_in        = 1'b1;
                  push               = 1'b1;
                  push_desc.tx_valid = 1'b1;
                  if (b == xcr_pkg::BYTE_CAN) begin
                     reply_in              = xcr_pkg::BYTE_ACK;
                     phase_in              = xcr_pkg::PH_IDLE;
                     push_desc.tx_byte     = xcr_pkg::BYTE_ACK;
                     push_desc.session_end = xcr_pkg::END_SENDER;
                  end else begin
                     reply_in          = xcr_pkg::BYTE_NAK;
                     phase_in          = xcr_pkg::PH_WAIT;
                     push_desc.tx_byte = xcr_pkg::BYTE_NAK;
                  end
               end
               xcr_pkg::PH_PART: begin
                  index_in = index_ff + 1'b1;
                  if (index_ff == xcr_pkg::INDEX_W'(1)) begin
                     hseq_in = b;
                  end else if (index_ff == xcr_pkg::INDEX_W'(2)) begin
                     hinv_in = b;
                  end else if (index_ff < DATA_END) begin
                     // Payload byte: fold into the CRC and forward it
                     crc_in               = crc_next;
                     push                 = 1'b1;
                     push_desc.data_valid = 1'b1;
                     push_desc.data_byte  = b;
                  end else if (index_ff == DATA_END) begin
                     rcrc_in = {b, 8'h00};
                  end else begin
                     // Low CRC byte closes the packet
                     rcrc_in  = rcrc_full;
                     index_in = '0;
                     phase_in = xcr_pkg::PH_WAIT;
                     push     = 1'b1;
                     if (pkt_good) begin
                        if (hseq_ff == exp_seq_ff) begin
                           exp_seq_in         = exp_seq_ff + 8'd1;
                           retries_in         = cfg.retry_limit;
                           reply_in           = xcr_pkg::BYTE_ACK;
                           push_desc.tx_valid = 1'b1;
                           push_desc.tx_byte  = xcr_pkg::BYTE_ACK;
                           push_desc.verdict  = xcr_pkg::VERDICT_NEW;
                        end else if (hseq_ff == exp_seq_ff - 8'd1) begin
                           reply_in           = xcr_pkg::BYTE_ACK;
                           push_desc.tx_valid = 1'b1;
                           push_desc.tx_byte  = xcr_pkg::BYTE_ACK;
                           push_desc.verdict  = xcr_pkg::VERDICT_DUP;
                        end else begin
                           // Out of sequence
                           phase_in       = xcr_pkg::PH_IDLE;
                           flushing_in    = 1'b1;
                           push_desc.kind = xcr_pkg::KIND_ABORT;
                        end
                     end else begin
                        reply_in          = xcr_pkg::BYTE_NAK;
                        flushing_in       = 1'b1;
                        retries_in        = retries_used;
                        push_desc.verdict = xcr_pkg::VERDICT_CORRUPT;
                        if (retry_hit) begin
                           phase_in       = xcr_pkg::PH_IDLE;
                           push_desc.kind = xcr_pkg::KIND_ABORT;
                        end else begin
                           push_desc.tx_valid = 1'b1;
                           push_desc.tx_byte  = xcr_pkg::BYTE_NAK;
                        end
                     end
                  end
               end
               default: begin
                  // Idle was handled above
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= xcr_pkg::PH_IDLE;
         reply_ff    <= xcr_pkg::BYTE_C;
         exp_seq_ff  <= 8'd1;
         retries_ff  <= '0;
         flushing_ff <= 1'b0;
         timeout_ff  <= '0;
         index_ff    <= '0;
         crc_ff      <= '0;
         hseq_ff     <= '0;
         hinv_ff     <= '0;
         rcrc_ff     <= '0;
      end else begin
         phase_ff    <= phase_in;
         reply_ff    <= reply_in;
         exp_seq_ff  <= exp_seq_in;
         retries_ff  <= retries_in;
         flushing_ff <= flushing_in;
         timeout_ff  <= timeout_in;
         index_ff    <= index_in;
         crc_ff      <= crc_in;
         hseq_ff     <= hseq_in;
         hinv_ff     <= hinv_in;
         rcrc_ff     <= rcrc_in;
      end
   end

endmodule

@@ rtl/xcr_back.sv @@
// Back part of the receiver: expands queued descriptors into result items and
// holds the output register. Depends on xcr_pkg.

module xcr_back (
   input  logic              clock,
   input  logic              reset,
   input  xcr_pkg::desc_type head,
   input  logic              empty,
   output logic              pop,
   output logic              out_valid,
   input  logic              out_stall,
   output xcr_pkg::rsp_type  out_item
);

   logic             out_valid_ff, out_valid_in;
   xcr_pkg::rsp_type out_item_ff, out_item_in;
   logic [1:0]       sub_ff, sub_in;
   logic             load;
   logic             final_res;
   xcr_pkg::rsp_type res;

   assign out_valid = out_valid_ff;
   assign out_item  = out_item_ff;
   assign load      = !empty && (!out_valid_ff || !out_stall);
   assign pop       = load && final_res;

   // Result item number sub_ff of the head descriptor
   always_comb begin
      res = '0;
      final_res = 1'b1;
      unique case (head.kind)
         xcr_pkg::KIND_CAN2: begin
            res.tx_valid = 1'b1;
            res.tx_byte  = xcr_pkg::BYTE_CAN;
            final_res    = (sub_ff == 2'd1);
            if (final_res) begin
               res.session_end = xcr_pkg::END_ABORT;
            end
         end
         xcr_pkg::KIND_ABORT: begin
            res.tx_valid = 1'b1;
            res.tx_byte  = xcr_pkg::BYTE_CAN;
            final_res    = (sub_ff == 2'd2);
            if (sub_ff == 2'd0) begin
               res.verdict = head.verdict;
            end
            if (final_res) begin
               res.session_end = xcr_pkg::END_ABORT;
            end
         end
         default: begin
            res.tx_valid    = head.tx_valid;
            res.tx_byte     = head.tx_byte;
            res.data_valid  = head.data_valid;
            res.data_byte   = head.data_byte;
            res.verdict     = head.verdict;
            res.session_end = head.session_end;
         end
      endcase
      res.last = final_res;
   end

   // Output register and position within the descriptor
   always_comb begin
      out_valid_in = out_valid_ff;
      out_item_in  = out_item_ff;
      sub_in       = sub_ff;
      if (load) begin
         out_valid_in = 1'b1;
         out_item_in  = res;
         sub_in       = final_res ? 2'd0 : sub_ff + 2'd1;
      end else if (!out_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         sub_ff       <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         sub_ff       <= sub_in;
      end
   end

   always_ff @(posedge clock) begin
      out_item_ff <= out_item_in;
   end

endmodule

@@ rtl/xmodem_crc_receiver_top.sv @@
// Top level of the XMODEM-CRC receiver: configuration registers and the
// front / queue / back parts. Depends on xcr_pkg, xcr_front, xcr_queue, xcr_back.
//
//   Channel   Direction  Handshake                 Payload
//   req_      in         req_valid / req_stall     req_data (action, rx_byte)
//   rsp_      out        rsp_valid / rsp_stall     rsp_data (tx, data, verdict, end, last)
//   APB       in/out     psel, penable, pready     paddr, pwdata, prdata
//
// The front decides an item in the cycle it is accepted and can take one item
// per cycle while the four-entry descriptor queue has room.
// Results leave the output register one per cycle while rsp_stall is low. An item
// yields up to three results, held in a queue entry and then the output register.
// Synchronous reset clears the session, the queue and the output valid flag.
// A stalled result holds in the output register while the queue keeps filling.

module xmodem_crc_receiver_top #(
   parameter int PACKET_BYTES = 128
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  xcr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output xcr_pkg::rsp_type rsp_data,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [3:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   xcr_pkg::cfg_type  cfg_ff, cfg_in;
   logic [1:0]        reg_index;
   logic              reg_write;
   logic              push, q_full, pop, q_empty;
   xcr_pkg::desc_type push_desc, head;

   assign pready    = 1'b1;
   assign reg_index = paddr[3:2];
   assign reg_write = psel && penable && pwrite;

   // Register write
   always_comb begin
      cfg_in = cfg_ff;
      if (reg_write) begin
         unique case (reg_index)
            xcr_pkg::REG_RETRY_LIMIT:   cfg_in.retry_limit         = pwdata[7:0];
            xcr_pkg::REG_FIRST_TIMEOUT: cfg_in.first_timeout_ticks = pwdata[15:0];
            xcr_pkg::REG_BYTE_TIMEOUT:  cfg_in.byte_timeout_ticks  = pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   // Register read
   always_comb begin
      unique case (reg_index)
         xcr_pkg::REG_RETRY_LIMIT:   prdata = {24'h0, cfg_ff.retry_limit};
         xcr_pkg::REG_FIRST_TIMEOUT: prdata = {16'h0, cfg_ff.first_timeout_ticks};
         xcr_pkg::REG_BYTE_TIMEOUT:  prdata = {16'h0, cfg_ff.byte_timeout_ticks};
         default:                    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.retry_limit         <= 8'd10;
         cfg_ff.first_timeout_ticks <= 16'd3000;
         cfg_ff.byte_timeout_ticks  <= 16'd1000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   xcr_front #(
      .PACKET_BYTES (PACKET_BYTES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_item   (req_data),
      .cfg       (cfg_ff),
      .push      (push),
      .push_desc (push_desc),
      .q_full    (q_full)
   );

   xcr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .full      (q_full),
      .pop       (pop),
      .head      (head),
      .empty     (q_empty)
   );

   xcr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .empty     (q_empty),
      .pop       (pop),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_item  (rsp_data)
   );

endmodule

@@ rtl/xcr_checker.sv @@
// Port-level checks on the receiver's result channel, bound to the top level.
// Depends on xcr_pkg and xmodem_crc_receiver_top.

module xcr_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input xcr_pkg::rsp_type rsp_data
);

   // No result may appear in the cycle after reset
   a_quiet_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown right after reset");

   // A stalled result stays
   a_valid_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result dropped or changed");

   // A session end closes the item
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.session_end != xcr_pkg::END_RUNNING) |-> rsp_data.last)
      else $error("session end on a result that is not the last");

   // A forwarded payload byte is a lone result with nothing to send
   a_data_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.data_valid |->
         !rsp_data.tx_valid && rsp_data.last && (rsp_data.verdict == xcr_pkg::VERDICT_NONE))
      else $error("payload byte mixed with a reply");

endmodule

bind xmodem_crc_receiver_top xcr_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
